// File: hdl/sks_pkg.sv
`timescale 1ns / 1ps

package sks_pkg;

  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLEARED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISS     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_PROBE
  } state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             ins;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] mid;
  } bcast_t;

  // compare result of the probed cell
  typedef struct packed {
    logic lt;
    logic eq;
  } probe_t;

endpackage

// File: hdl/sks_cell.sv
`timescale 1ns / 1ps

module sks_cell (
  input  logic                          clk_i,
  input  logic [sks_pkg::IDX_W-1:0]     idx_i,
  input  sks_pkg::bcast_t               bc_i,
  input  logic [sks_pkg::KEY_W-1:0]     prev_key_i,
  input  logic                          prev_gt_i,
  output logic [sks_pkg::KEY_W-1:0]     key_o,
  output logic                          gt_o,
  output sks_pkg::probe_t               probe_o
);

  logic [sks_pkg::KEY_W-1:0] key_q, key_d;
  logic [sks_pkg::CNT_W-1:0] idx_ext;
  logic                      in_use, is_tail, is_mid;

  assign idx_ext = sks_pkg::CNT_W'(idx_i);
  assign in_use  = idx_ext < bc_i.count;
  assign is_tail = idx_ext == bc_i.count;
  assign is_mid  = idx_i == bc_i.mid;

  assign gt_o = in_use && (key_q > bc_i.key);

  // open a gap where the new key lands, shift larger keys up by one
  always_comb begin
    key_d = key_q;
    if (bc_i.ins && (gt_o || is_tail)) begin
      key_d = prev_gt_i ? prev_key_i : bc_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o      = key_q;
  assign probe_o.lt = is_mid && (key_q < bc_i.key);
  assign probe_o.eq = is_mid && (key_q == bc_i.key);

endmodule

// File: hdl/sks_ctrl.sv
`timescale 1ns / 1ps

module sks_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sks_pkg::OP_W-1:0]      op_i,
  input  logic [sks_pkg::KEY_W-1:0]     key_i,
  input  sks_pkg::probe_t               probe_i,
  output sks_pkg::bcast_t               bc_o,
  output logic                          busy_o,
  output logic                          result_valid_o,
  output logic [sks_pkg::STATUS_W-1:0]  status_o,
  output logic [sks_pkg::POS_W-1:0]     position_o
);

  localparam int unsigned CW = sks_pkg::CNT_W;

  sks_pkg::state_e            state_q, state_d;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              lo_q, lo_d, hi_q, hi_d;
  logic [sks_pkg::KEY_W-1:0]  key_q, key_d;
  logic                       valid_q, valid_d;
  sks_pkg::status_e           status_q, status_d;
  logic [sks_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [CW:0]                mid_sum;
  logic [CW-1:0]              mid_full, mid_inc;
  logic                       accept;

  assign accept   = start_i && (state_q == sks_pkg::S_IDLE);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
  assign mid_full = mid_sum[CW:1];
  assign mid_inc  = mid_full + {{(CW-1){1'b0}}, 1'b1};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    key_d    = key_q;
    valid_d  = 1'b0;
    status_d = status_q;
    pos_d    = pos_q;
    case (state_q)
      sks_pkg::S_IDLE: begin
        if (accept) begin
          key_d = key_i;
          case (op_i)
            sks_pkg::OP_CLEAR: begin
              count_d  = '0;
              valid_d  = 1'b1;
              status_d = sks_pkg::ST_CLEARED;
              pos_d    = '0;
            end
            sks_pkg::OP_INSERT: begin
              if (count_q == CW'(sks_pkg::TABLE_DEPTH)) begin
                valid_d  = 1'b1;
                status_d = sks_pkg::ST_FULL;
                pos_d    = '0;
              end else begin
                state_d = sks_pkg::S_INSERT;
              end
            end
            sks_pkg::OP_SEARCH: begin
              lo_d    = '0;
              hi_d    = count_q;
              state_d = sks_pkg::S_PROBE;
            end
            default: ;
          endcase
        end
      end
      sks_pkg::S_INSERT: begin
        count_d  = count_q + {{(CW-1){1'b0}}, 1'b1};
        valid_d  = 1'b1;
        status_d = sks_pkg::ST_INSERTED;
        pos_d    = '0;
        state_d  = sks_pkg::S_IDLE;
      end
      sks_pkg::S_PROBE: begin
        if (lo_q >= hi_q) begin
          valid_d  = 1'b1;
          status_d = sks_pkg::ST_MISS;
          pos_d    = '0;
          state_d  = sks_pkg::S_IDLE;
        end else if (probe_i.eq) begin
          valid_d  = 1'b1;
          status_d = sks_pkg::ST_FOUND;
          pos_d    = sks_pkg::POS_W'(mid_inc);
          state_d  = sks_pkg::S_IDLE;
        end else if (probe_i.lt) begin
          lo_d = mid_inc;
        end else begin
          hi_d = mid_full;
        end
      end
      default: state_d = sks_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sks_pkg::S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    key_q    <= key_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  assign bc_o.ins       = (state_q == sks_pkg::S_INSERT);
  assign bc_o.key       = key_q;
  assign bc_o.count     = count_q;
  assign bc_o.mid       = mid_full[sks_pkg::IDX_W-1:0];
  assign busy_o         = (state_q != sks_pkg::S_IDLE);
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign position_o     = pos_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(sks_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sks_pkg::S_PROBE) |-> (hi_q <= count_q))
    else $error("search range beyond stored entries");

  a_full_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == sks_pkg::OP_INSERT && count_q == CW'(sks_pkg::TABLE_DEPTH))
    |=> (valid_q && status_q == sks_pkg::ST_FULL && count_q == $past(count_q)))
    else $error("insert into full table not rejected");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (state_q == sks_pkg::S_IDLE))
    else $error("result raised while still busy");

  a_insert_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sks_pkg::S_INSERT) |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow table");

endmodule

// File: hdl/sorted_key_table_search.sv
`timescale 1ns / 1ps

// sorted key table with insert and binary search
//
// a command transaction is taken at a rising edge with start high and busy low;
// op_i selects clear, insert or search, key_i carries the key (ignored by clear).
// op code 3 is accepted and does nothing, no result follows it.
// each result is shown on status_o / position_o for exactly one cycle, marked by
// result_valid_o; the receiver cannot stall, so nothing is ever held back.
// steps from accept to result:
//   clear, insert into a full table : result registered straight from the idle state
//   insert                          : through S_INSERT, where the row shifts
//   search                          : one probe per cycle in S_PROBE until a hit,
//                                     or until the range is seen to be empty
// busy stays high until the result cycle, so one command is in flight at a time.
// keys live in a row of cells, one key per cell, kept in ascending order; an insert
// moves every larger key one cell up in the same cycle, each cell taking its
// neighbor's key.
// reset clears the entry count, the state and the result flag; cell contents stay
// undefined until written, and only cells below the entry count are ever compared.

module sorted_key_table_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sks_pkg::OP_W-1:0]      op_i,
  input  logic [sks_pkg::KEY_W-1:0]     key_i,
  output logic                          result_valid_o,
  output logic [sks_pkg::STATUS_W-1:0]  status_o,
  output logic [sks_pkg::POS_W-1:0]     position_o
);

  localparam int unsigned DEPTH = sks_pkg::TABLE_DEPTH;
  localparam int unsigned IW    = sks_pkg::IDX_W;

  sks_pkg::bcast_t            bc;
  sks_pkg::probe_t            probe;
  sks_pkg::probe_t            cell_probe [DEPTH];
  logic [sks_pkg::KEY_W-1:0]  cell_key   [DEPTH];
  logic                       cell_gt    [DEPTH];

  // controller: entry count, search range and result register
  sks_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .op_i           (op_i),
    .key_i          (key_i),
    .probe_i        (probe),
    .bc_o           (bc),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .position_o     (position_o)
  );

  // row of key cells; cell 0 holds the smallest key
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [sks_pkg::KEY_W-1:0] prev_key;
    logic                      prev_gt;

    if (i == 0) begin : g_head
      // nothing below the first cell, the new key always lands here if it moves
      assign prev_key = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    sks_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (IW'(i)),
      .bc_i       (bc),
      .prev_key_i (prev_key),
      .prev_gt_i  (prev_gt),
      .key_o      (cell_key[i]),
      .gt_o       (cell_gt[i]),
      .probe_o    (cell_probe[i])
    );
  end

  // only the cell at the probe index drives a nonzero compare result
  always_comb begin
    probe = '0;
    for (int j = 0; j < DEPTH; j++) begin
      probe.lt = probe.lt | cell_probe[j].lt;
      probe.eq = probe.eq | cell_probe[j].eq;
    end
  end

endmodule
